// ===== sv/assert_macros.svh =====
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/lcasr_pkg.sv =====
package lcasr_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int MAX_CHANNELS = 3;
   localparam int TICK_W       = 8;
   localparam int PULSE_W      = 5;
   localparam int GAIN_W       = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 8;

   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = 24'h800000;

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_SELECT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_PERIOD = 1'd1;

   localparam logic [GAIN_W-1:0] GAIN_128 = 2'd0;
   localparam logic [GAIN_W-1:0] GAIN_32  = 2'd1;
   localparam logic [GAIN_W-1:0] GAIN_64  = 2'd2;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW
   } phase_type;

   typedef struct packed {
      logic clear;
      logic shift;
      logic done;
      logic clock_level;
      logic busy;
   } ctrl_type;

   function automatic logic [PULSE_W-1:0] total_pulses(input logic [GAIN_W-1:0] gain);
      logic [PULSE_W-1:0] total;
      unique case (gain)
         GAIN_32: total = PULSE_W'(SAMPLE_BITS + 2);
         GAIN_64: total = PULSE_W'(SAMPLE_BITS + 3);
         default: total = PULSE_W'(SAMPLE_BITS + 1);
      endcase
      return total;
   endfunction

endpackage

// ===== sv/lcasr_if.sv =====
interface lcasr_req_if;
   logic       valid;
   logic       ready;
   logic       read_request;
   logic [2:0] data_lines;

   modport source (output valid, read_request, data_lines, input ready);
   modport sink (input valid, read_request, data_lines, output ready);
endinterface

interface lcasr_rsp_if;
   logic        valid;
   logic        ready;
   logic        clock_level;
   logic        busy_res;
   logic        sample_valid;
   logic [23:0] sample_one;
   logic [23:0] sample_two;
   logic [23:0] sample_three;

   modport source (output valid, clock_level, busy_res, sample_valid,
                   sample_one, sample_two, sample_three, input ready);
   modport sink (input valid, clock_level, busy_res, sample_valid,
                 sample_one, sample_two, sample_three, output ready);
endinterface

// ===== sv/lcasr_csr.sv =====
module lcasr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [lcasr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lcasr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [lcasr_pkg::GAIN_W-1:0]        gain_select,
   output logic [lcasr_pkg::TICK_W-1:0]        half_period
);
   import lcasr_pkg::*;

   logic [GAIN_W-1:0] gain_ff;
   logic [TICK_W-1:0] half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_128;
         half_ff <= TICK_W'(1);
      end else if (csr_write_en) begin
         if (csr_index == REG_GAIN_SELECT) begin
            gain_ff <= csr_wdata[GAIN_W-1:0];
         end
         if (csr_index == REG_HALF_PERIOD) begin
            half_ff <= csr_wdata[TICK_W-1:0];
         end
      end
   end

   assign gain_select = gain_ff;
   assign half_period = half_ff;

endmodule

// ===== sv/lcasr_ctrl.sv =====
module lcasr_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              read_request,
   input  logic                              lines_zero,
   input  logic [lcasr_pkg::GAIN_W-1:0]      gain_select,
   input  logic [lcasr_pkg::TICK_W-1:0]      half_period,
   output lcasr_pkg::ctrl_type               ctrl
);
   import lcasr_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [PULSE_W-1:0]   pulse_ff, pulse_in;
   logic [TICK_W-1:0]    tick_inc;
   logic [PULSE_W-1:0]   pulse_inc;
   logic                 tick_end;
   logic                 last_pulse;

   assign tick_inc   = tick_ff + TICK_W'(1);
   assign tick_end   = (tick_inc >= half_period) || (tick_inc == '0);
   assign pulse_inc  = pulse_ff + PULSE_W'(1);
   assign last_pulse = pulse_inc >= total_pulses(gain_select);

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      pulse_in = pulse_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (read_request) begin
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (lines_zero) begin
               phase_in = PH_HIGH;
               tick_in  = '0;
               pulse_in = '0;
            end
         end
         PH_HIGH: begin
            tick_in = tick_end ? '0 : tick_inc;
            if (tick_end) begin
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            tick_in = tick_end ? '0 : tick_inc;
            if (tick_end) begin
               if (last_pulse) begin
                  phase_in = PH_IDLE;
                  pulse_in = '0;
               end else begin
                  phase_in = PH_HIGH;
                  pulse_in = pulse_inc;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      ctrl.clear       = (phase_ff == PH_WAIT) && lines_zero;
      ctrl.shift       = (phase_ff == PH_LOW) && tick_end
                         && (pulse_ff < PULSE_W'(SAMPLE_BITS));
      ctrl.done        = (phase_ff == PH_LOW) && tick_end && last_pulse;
      ctrl.clock_level = (phase_in == PH_HIGH);
      ctrl.busy        = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         pulse_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         pulse_ff <= pulse_in;
      end
   end

endmodule

// ===== sv/lcasr_shift.sv =====
module lcasr_shift #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic                                                      clock,
   input  logic                                                      step,
   input  lcasr_pkg::ctrl_type                                       ctrl,
   input  logic [lcasr_pkg::MAX_CHANNELS-1:0]                        data_lines,
   output logic [lcasr_pkg::MAX_CHANNELS-1:0][lcasr_pkg::SAMPLE_BITS-1:0] samples
);
   import lcasr_pkg::*;

   for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_chan
      if (k < NUM_CHANNELS) begin : g_active
         sample_type shift_ff, shift_in;

         always_comb begin
            priority if (ctrl.clear) begin
               shift_in = '0;
            end else if (ctrl.shift) begin
               shift_in = {shift_ff[SAMPLE_BITS-2:0], data_lines[k]};
            end else begin
               shift_in = shift_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (step) begin
               shift_ff <= shift_in;
            end
         end

         assign samples[k] = shift_ff ^ SIGN_FLIP;
      end else begin : g_unused
         assign samples[k] = '0;
      end
   end

endmodule

// ===== sv/load_cell_adc_serial_reader_core.sv =====
// Serial readout sequencer for up to NUM_CHANNELS bridge-sensor converters on one shared
// serial clock. Every request is one tick and yields one response in the next cycle; a new
// request is taken every cycle while the response register is free or being drained, so
// the sustained rate is one tick per cycle, set by the single state register stage. A read
// request in idle waits for all active data lines low, clocks 24 data pulses plus 1 to 3
// gain pulses (gain_select), each half_period ticks (at least one) high then low, and
// reports the offset-binary samples with sample_valid high for one response.
module load_cell_adc_serial_reader_core #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   lcasr_req_if.sink                           req_chan,
   lcasr_rsp_if.source                         rsp_chan,
   input  logic                                csr_write_en,
   input  logic [lcasr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lcasr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lcasr_pkg::*;

   localparam logic [MAX_CHANNELS-1:0] ACTIVE_MASK =
      MAX_CHANNELS'((1 << NUM_CHANNELS) - 1);

   logic [GAIN_W-1:0]                        gain_select;
   logic [TICK_W-1:0]                        half_period;
   logic                                     step;
   logic                                     lines_zero;
   ctrl_type                                 ctrl;
   logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] samples;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       clock_level_ff;
   logic       busy_ff;
   logic       sample_valid_ff;
   sample_type sample_one_ff;
   sample_type sample_two_ff;
   sample_type sample_three_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_chan.valid && req_chan.ready;
   assign lines_zero     = (req_chan.data_lines & ACTIVE_MASK) == '0;

   lcasr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .gain_select  (gain_select),
      .half_period  (half_period)
   );

   lcasr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .read_request (req_chan.read_request),
      .lines_zero   (lines_zero),
      .gain_select  (gain_select),
      .half_period  (half_period),
      .ctrl         (ctrl)
   );

   lcasr_shift #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_shift (
      .clock      (clock),
      .step       (step),
      .ctrl       (ctrl),
      .data_lines (req_chan.data_lines),
      .samples    (samples)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         clock_level_ff  <= ctrl.clock_level;
         busy_ff         <= ctrl.busy;
         sample_valid_ff <= ctrl.done;
         sample_one_ff   <= ctrl.done ? samples[0] : '0;
         sample_two_ff   <= ctrl.done ? samples[1] : '0;
         sample_three_ff <= ctrl.done ? samples[2] : '0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.clock_level  = clock_level_ff;
   assign rsp_chan.busy_res     = busy_ff;
   assign rsp_chan.sample_valid = sample_valid_ff;
   assign rsp_chan.sample_one   = sample_one_ff;
   assign rsp_chan.sample_two   = sample_two_ff;
   assign rsp_chan.sample_three = sample_three_ff;

endmodule

// ===== sv/lcasr_checker.sv =====
`include "assert_macros.svh"

module lcasr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        clock_level,
   input logic        busy_res,
   input logic        sample_valid,
   input logic [23:0] sample_one,
   input logic [23:0] sample_two,
   input logic [23:0] sample_three
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLIES(a_done_idle, clock, reset, rsp_valid && sample_valid, !busy_res && !clock_level)
   `ASSERT_IMPLIES(a_clock_busy, clock, reset, rsp_valid && clock_level, busy_res)
   `ASSERT_IMPLIES(a_zero_samples, clock, reset, rsp_valid && !sample_valid, (sample_one == '0) && (sample_two == '0) && (sample_three == '0))

endmodule

bind load_cell_adc_serial_reader_core lcasr_checker u_lcasr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .clock_level  (rsp_chan.clock_level),
   .busy_res     (rsp_chan.busy_res),
   .sample_valid (rsp_chan.sample_valid),
   .sample_one   (rsp_chan.sample_one),
   .sample_two   (rsp_chan.sample_two),
   .sample_three (rsp_chan.sample_three)
);

// ===== verif/load_cell_adc_serial_reader_core_test.sv =====
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_core_test;
   import lcasr_pkg::*;

   localparam int NUM_CH      = 3;
   localparam int STALL_LIMIT = 2000;
   localparam int NUM_PHASES  = 6;

   typedef struct packed {
      logic       clock_level;
      logic       busy;
      logic       valid;
      sample_type one;
      sample_type two;
      sample_type three;
   } reading_type;

   typedef struct packed {
      logic        rq;
      logic [2:0]  lines;
      logic [15:0] reps;
      logic        typed;
      reading_type want;
   } plan_row_type;

   localparam reading_type QUIET      = '{1'b0, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0};
   localparam reading_type WAITING    = '{1'b0, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0};
   localparam reading_type CLOCK_HIGH = '{1'b1, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0};

   logic clock;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lcasr_req_if req ();
   lcasr_rsp_if rsp ();

   load_cell_adc_serial_reader_core #(.NUM_CHANNELS(NUM_CH)) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req),
      .rsp_chan     (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Directed ticks, starting from reset settings (gain 128, half period 1)
   plan_row_type plan [16] = '{
      '{1'b0, 3'd7, 16'd1, 1'b1, QUIET},
      '{1'b0, 3'd0, 16'd1, 1'b1, QUIET},
      '{1'b1, 3'd7, 16'd1, 1'b1, WAITING},
      '{1'b1, 3'd7, 16'd1, 1'b1, WAITING},
      '{1'b0, 3'd4, 16'd1, 1'b1, WAITING},
      '{1'b0, 3'd0, 16'd1, 1'b1, CLOCK_HIGH},
      '{1'b0, 3'd5, 16'd49, 1'b0, QUIET},
      '{1'b0, 3'd5, 16'd1, 1'b1, '{1'b0, 1'b0, 1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}},
      '{1'b0, 3'd2, 16'd1, 1'b1, QUIET},
      '{1'b1, 3'd0, 16'd1, 1'b1, WAITING},
      '{1'b0, 3'd0, 16'd1, 1'b1, CLOCK_HIGH},
      '{1'b0, 3'd1, 16'd1, 1'b1, WAITING},
      '{1'b0, 3'd2, 16'd48, 1'b0, QUIET},
      '{1'b0, 3'd2, 16'd1, 1'b1, '{1'b0, 1'b0, 1'b1, 24'h800000, 24'h7FFFFF, 24'h800000}},
      '{1'b1, 3'd3, 16'd1, 1'b1, WAITING},
      '{1'b0, 3'd3, 16'd6, 1'b0, QUIET}
   };

   logic [1:0] phase_gain [NUM_PHASES] = '{GAIN_64, GAIN_32, 2'd3, GAIN_128, GAIN_64, GAIN_32};
   int unsigned phase_half [NUM_PHASES] = '{1, 2, 0, 3, 1, 1};
   int unsigned phase_items [NUM_PHASES] = '{60, 60, 60, 60, 50, 60};

   // predicted sequencer state
   phase_type  sim_phase;
   logic [7:0] sim_ticks;
   logic [4:0] sim_pulses;
   sample_type sim_shift [NUM_CH];
   logic [1:0] sim_gain;
   logic [7:0] sim_half;

   reading_type readings_due [$];
   int unsigned errors;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stall_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic readout_tick(input logic rq, input logic [2:0] lines_in,
                               output reading_type r);
      logic [2:0] lines;
      logic [4:0] total;
      logic       done;
      lines = lines_in & 3'((1 << NUM_CH) - 1);
      done  = 1'b0;
      case (sim_gain)
         GAIN_32: total = 5'(SAMPLE_BITS + 2);
         GAIN_64: total = 5'(SAMPLE_BITS + 3);
         default: total = 5'(SAMPLE_BITS + 1);
      endcase
      case (sim_phase)
         PH_IDLE: begin
            if (rq) sim_phase = PH_WAIT;
         end
         PH_WAIT: begin
            if (lines == 3'd0) begin
               sim_phase  = PH_HIGH;
               sim_ticks  = '0;
               sim_pulses = '0;
               for (int k = 0; k < NUM_CH; k++) sim_shift[k] = '0;
            end
         end
         PH_HIGH: begin
            sim_ticks = sim_ticks + 8'd1;
            if (sim_ticks >= sim_half || sim_ticks == 8'd0) begin
               sim_ticks = '0;
               sim_phase = PH_LOW;
            end
         end
         PH_LOW: begin
            sim_ticks = sim_ticks + 8'd1;
            if (sim_ticks >= sim_half || sim_ticks == 8'd0) begin
               sim_ticks = '0;
               if (sim_pulses < 5'(SAMPLE_BITS))
                  for (int k = 0; k < NUM_CH; k++)
                     sim_shift[k] = {sim_shift[k][SAMPLE_BITS-2:0], lines[k]};
               sim_pulses = sim_pulses + 5'd1;
               if (sim_pulses >= total) begin
                  done       = 1'b1;
                  sim_phase  = PH_IDLE;
                  sim_pulses = '0;
               end else begin
                  sim_phase = PH_HIGH;
               end
            end
         end
         default: sim_phase = PH_IDLE;
      endcase
      r = QUIET;
      r.clock_level = (sim_phase == PH_HIGH);
      r.busy        = (sim_phase != PH_IDLE);
      r.valid       = done;
      if (done) begin
         r.one   = sim_shift[0] ^ SIGN_FLIP;
         r.two   = (NUM_CH > 1) ? sim_shift[1] ^ SIGN_FLIP : '0;
         r.three = (NUM_CH > 2) ? sim_shift[2] ^ SIGN_FLIP : '0;
      end
   endtask

   // entered and left at a falling edge
   task automatic send_tick(input logic rq, input logic [2:0] lines, input logic typed,
                            input reading_type want);
      reading_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.read_request <= rq;
      req.data_lines   <= lines;
      do @(posedge clock); while (!req.ready);
      readout_tick(rq, lines, r);
      readings_due.push_back(typed ? want : r);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      req.valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == REG_GAIN_SELECT) sim_gain = data[1:0];
      else sim_half = data;
   endtask

   task automatic check_field(input string name, input logic [23:0] got,
                              input logic [23:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(negedge clock)
      rsp.ready <= reset ? 1'b1 : ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (readings_due.size() == 0) begin
            flag_mismatch("response with no request pending");
         end else begin
            want = readings_due.pop_front();
            check_field("clock_level", 24'(rsp.clock_level), 24'(want.clock_level));
            check_field("busy_res", 24'(rsp.busy_res), 24'(want.busy));
            check_field("sample_valid", 24'(rsp.sample_valid), 24'(want.valid));
            check_field("sample_one", rsp.sample_one, want.one);
            check_field("sample_two", rsp.sample_two, want.two);
            check_field("sample_three", rsp.sample_three, want.three);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_en || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] gain_word;
      req.valid        = 1'b0;
      req.read_request = 1'b0;
      req.data_lines   = 3'd0;
      rsp.ready        = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = REG_GAIN_SELECT;
      csr_wdata        = '0;
      reset            = 1'b1;
      errors           = 0;
      stall_cycles     = 0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      sim_phase        = PH_IDLE;
      sim_ticks        = '0;
      sim_pulses       = '0;
      sim_gain         = GAIN_128;
      sim_half         = 8'd1;
      for (int k = 0; k < NUM_CH; k++) sim_shift[k] = '0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i])
         for (int r = 0; r < plan[i].reps; r++)
            send_tick(plan[i].rq, plan[i].lines, plan[i].typed, plan[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p % 3)
            0: begin send_idle_pct = 23; recv_idle_pct = 57; end
            1: begin send_idle_pct = 57; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         gain_word = {6'($urandom_range(63)), phase_gain[p]};
         write_register(REG_GAIN_SELECT, gain_word);
         write_register(REG_HALF_PERIOD, 8'(phase_half[p]));
         for (int n = 0; n < phase_items[p]; n++)
            send_tick($urandom_range(3) == 0, 3'($urandom_range(7)), 1'b0, QUIET);
         // let any read in flight run to its end
         while (sim_phase != PH_IDLE)
            send_tick(1'b0, 3'($urandom_range(7)), 1'b0, QUIET);
      end

      req.valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
